// ===== rtl/uvn_pkg.sv =====
// Shared constants, beat types and the per-bit quotient step of the vector normaliser.
`default_nettype none
package uvn_pkg;

    localparam int CW = 16;
    localparam int FRAC_BITS = 14;
    localparam int UW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int SW = 2 * CW;
    localparam int DW = 2 * CW + 2 * FRAC_BITS + 4;
    localparam int BW = $clog2(FRAC_BITS + 1);
    localparam int NBITS = FRAC_BITS + 1;

    typedef struct packed {
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
    } in_t;

    typedef struct packed {
        logic signed [UW-1:0] x_unit;
        logic signed [UW-1:0] y_unit;
        logic                 ok;
    } out_t;

    // d: 4*a^2*2^(2F) - (2q-1)^2*s, p: (2q-1)*s
    typedef struct packed {
        logic                 neg;
        logic [QW-1:0]        q;
        logic signed [DW-1:0] d;
        logic signed [DW-1:0] p;
    } lane_t;

    typedef struct packed {
        logic [SW-1:0] s;
        lane_t         x;
        lane_t         y;
    } work_t;

    function automatic lane_t lane_step(lane_t l, logic [SW-1:0] s, logic [BW-1:0] bidx);
        logic signed [DW-1:0] sx;
        logic signed [DW-1:0] t;
        lane_t                r;
        sx = $signed({{(DW-SW){1'b0}}, s});
        t  = (l.p <<< ({1'b0, bidx} + 2'd2)) + (sx <<< ({bidx, 1'b0} + 2'd2));
        r  = l;
        if (l.d >= t)
        begin
            r.d = l.d - t;
            r.p = l.p + (sx <<< ({1'b0, bidx} + 2'd1));
            r.q = l.q | (QW'(1) << bidx);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/uvn_prep.sv =====
// Front end: magnitudes and squares, then sum of squares and initial remainders.
`default_nettype none
module uvn_prep (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_vld,
    output logic               in_rdy,
    input  uvn_pkg::in_t       in_data,
    output logic               out_vld,
    input  wire logic          out_rdy,
    output uvn_pkg::work_t     out_data
);

    logic                      v1_reg;
    logic [uvn_pkg::SW-1:0]    ax2_reg;
    logic [uvn_pkg::SW-1:0]    ay2_reg;
    logic                      nx_reg;
    logic                      ny_reg;
    logic                      rdy1;
    logic                      v2_reg;
    uvn_pkg::work_t            w_reg;
    uvn_pkg::work_t            w_next;
    logic [uvn_pkg::CW-1:0]    ax;
    logic [uvn_pkg::CW-1:0]    ay;
    logic [uvn_pkg::SW-1:0]    s;

    assign ax = in_data.x_in[uvn_pkg::CW-1] ? (~in_data.x_in + 1'b1) : in_data.x_in;
    assign ay = in_data.y_in[uvn_pkg::CW-1] ? (~in_data.y_in + 1'b1) : in_data.y_in;

    assign rdy1   = !v2_reg || out_rdy;
    assign in_rdy = !v1_reg || rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            v1_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld && in_rdy)
        begin
            ax2_reg <= uvn_pkg::SW'(ax) * uvn_pkg::SW'(ax);
            ay2_reg <= uvn_pkg::SW'(ay) * uvn_pkg::SW'(ay);
            nx_reg  <= in_data.x_in[uvn_pkg::CW-1];
            ny_reg  <= in_data.y_in[uvn_pkg::CW-1];
        end
    end

    assign s = ax2_reg + ay2_reg;

    always_comb
    begin
        w_next.s     = s;
        w_next.x.neg = nx_reg;
        w_next.x.q   = '0;
        w_next.x.p   = -$signed({{(uvn_pkg::DW-uvn_pkg::SW){1'b0}}, s});
        w_next.x.d   = ($signed({{(uvn_pkg::DW-uvn_pkg::SW){1'b0}}, ax2_reg})
                        <<< (2 * uvn_pkg::FRAC_BITS + 2)) + w_next.x.p;
        w_next.y.neg = ny_reg;
        w_next.y.q   = '0;
        w_next.y.p   = w_next.x.p;
        w_next.y.d   = ($signed({{(uvn_pkg::DW-uvn_pkg::SW){1'b0}}, ay2_reg})
                        <<< (2 * uvn_pkg::FRAC_BITS + 2)) + w_next.x.p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && rdy1)
        begin
            w_reg <= w_next;
        end
    end

    assign out_vld  = v2_reg;
    assign out_data = w_reg;

endmodule
`default_nettype wire

// ===== rtl/uvn_iter.sv =====
// One restoring step: decides one quotient bit of both components.
`default_nettype none
module uvn_iter (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [uvn_pkg::BW-1:0] bidx,
    input  wire logic               in_vld,
    output logic                    in_rdy,
    input  uvn_pkg::work_t          in_data,
    output logic                    out_vld,
    input  wire logic               out_rdy,
    output uvn_pkg::work_t          out_data
);

    logic           vld_reg;
    uvn_pkg::work_t data_reg;
    uvn_pkg::work_t data_next;

    assign in_rdy = !vld_reg || out_rdy;

    always_comb
    begin
        data_next   = in_data;
        data_next.x = uvn_pkg::lane_step(in_data.x, in_data.s, bidx);
        data_next.y = uvn_pkg::lane_step(in_data.y, in_data.s, bidx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld && in_rdy)
        begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule
`default_nettype wire

// ===== rtl/uvn_finish.sv =====
// Output stage: applies signs, clears the zero vector, holds the result beat.
`default_nettype none
module uvn_finish (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_vld,
    output logic           in_rdy,
    input  uvn_pkg::work_t in_data,
    output logic           out_vld,
    input  wire logic      out_rdy,
    output uvn_pkg::out_t  out_data
);

    logic                   vld_reg;
    uvn_pkg::out_t          res_reg;
    uvn_pkg::out_t          res_next;
    logic [uvn_pkg::UW-1:0] xm;
    logic [uvn_pkg::UW-1:0] ym;
    logic                   nz;

    assign in_rdy = !vld_reg || out_rdy;
    assign xm = uvn_pkg::UW'(in_data.x.q);
    assign ym = uvn_pkg::UW'(in_data.y.q);
    assign nz = (in_data.s != '0);

    always_comb
    begin
        res_next.x_unit = '0;
        res_next.y_unit = '0;
        res_next.ok     = nz;
        if (nz)
        begin
            res_next.x_unit = $signed(in_data.x.neg ? (~xm + 1'b1) : xm);
            res_next.y_unit = $signed(in_data.y.neg ? (~ym + 1'b1) : ym);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld && in_rdy)
        begin
            res_reg <= res_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = res_reg;

endmodule
`default_nettype wire

// ===== rtl/unit_vector_normalize.sv =====
// Top level: 2D vector to rounded Q1.14 unit vector, fully pipelined.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data  (x_in, y_in)
//  out     | output    | out_valid/out_stall| out_data (x_unit, y_unit, ok)
//
// One beat per cycle sustained while out is not stalled; beats pass through uvn_prep, the
// one-bit-per-stage restoring quotient chain and uvn_finish.
// Every stage has its own valid bit; a bubble is filled even while out is stalled.
// Reset clears the valid bits only; no state persists between beats.
`default_nettype none
module unit_vector_normalize (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  uvn_pkg::in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output uvn_pkg::out_t out_data
);

    logic           vld [0:uvn_pkg::NBITS];
    logic           rdy [0:uvn_pkg::NBITS];
    uvn_pkg::work_t wd  [0:uvn_pkg::NBITS];
    logic           in_rdy;

    assign in_stall = !in_rdy;

    uvn_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_valid),
        .in_rdy   (in_rdy),
        .in_data  (in_data),
        .out_vld  (vld[0]),
        .out_rdy  (rdy[0]),
        .out_data (wd[0])
    );

    for (genvar gi = 0; gi < uvn_pkg::NBITS; gi++)
    begin : g_bit
        uvn_iter u_iter (
            .clk      (clk),
            .rst_n    (rst_n),
            .bidx     (uvn_pkg::BW'(uvn_pkg::FRAC_BITS - gi)),
            .in_vld   (vld[gi]),
            .in_rdy   (rdy[gi]),
            .in_data  (wd[gi]),
            .out_vld  (vld[gi+1]),
            .out_rdy  (rdy[gi+1]),
            .out_data (wd[gi+1])
        );
    end

    uvn_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld[uvn_pkg::NBITS]),
        .in_rdy   (rdy[uvn_pkg::NBITS]),
        .in_data  (wd[uvn_pkg::NBITS]),
        .out_vld  (out_valid),
        .out_rdy  (!out_stall),
        .out_data (out_data)
    );

`ifndef ASSERT_OFF
    a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ok |-> out_data.x_unit == '0 && out_data.y_unit == '0)
        else $error("zero vector beat has nonzero components");
    a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.x_unit <= $signed(uvn_pkg::UW'(1 << uvn_pkg::FRAC_BITS))
                   && out_data.x_unit >= -$signed(uvn_pkg::UW'(1 << uvn_pkg::FRAC_BITS)))
        else $error("x_unit beyond unit magnitude");
    a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.y_unit <= $signed(uvn_pkg::UW'(1 << uvn_pkg::FRAC_BITS))
                   && out_data.y_unit >= -$signed(uvn_pkg::UW'(1 << uvn_pkg::FRAC_BITS)))
        else $error("y_unit beyond unit magnitude");
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.ok |-> out_data.x_unit != '0 || out_data.y_unit != '0)
        else $error("normalised beat with zero length");
`endif

endmodule
`default_nettype wire
